/* rtl/bsl_pkg.sv */
package bsl_pkg;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_EQUALS = 8'h3D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic KIND_TEXT = 1'b0;
  localparam logic KIND_EOI  = 1'b1;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       token_end;
  } result_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

/* rtl/bsl_in_if.sv */
interface bsl_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_byte;

  modport source (output valid, output kind, output in_byte, input ready);
  modport sink (input valid, input kind, input in_byte, output ready);
endinterface

/* rtl/bsl_out_if.sv */
interface bsl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       token_end;

  modport source (output valid, output out_byte, output token_end, input ready);
  modport sink (input valid, input out_byte, input token_end, output ready);
endinterface

/* rtl/brace_script_lexer_core.sv */
// Brace-script lexer. One text or end-of-input item is taken per cycle while the
// four-entry result queue has room for two results; the lexing decision for an
// item is made in the cycle it is accepted and its results enter the queue at
// the end of that cycle. Results leave at one token byte per cycle while the
// output port takes them; an item that closes a token and also emits a brace,
// '=' or closing quote gives two results, so the input rate falls below one
// item per cycle only while such items arrive faster than the output drains
// the queue, or while the output port holds off and the queue fills.
module brace_script_lexer_core
  import bsl_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  bsl_in_if.sink    text,
  bsl_out_if.source tokens
);

  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [7:0] held_byte;
    logic       held_valid;
    logic [1:0] token_length;
    logic       quoted_mode;
    logic       raw_literal_mode;
    logic       comment_mode;
    logic [7:0] previous_byte;
  } lex_state_t;

  typedef struct packed {
    lex_state_t st;
    result_t    r0;
    result_t    r1;
    logic [1:0] n;
  } lex_t;

  function automatic lex_t f_emit(input lex_t s, input logic [7:0] b, input logic last);
    lex_t o;
    o = s;
    if (s.n == 2'd0) begin
      o.r0 = '{out_byte: b, token_end: last};
    end else begin
      o.r1 = '{out_byte: b, token_end: last};
    end
    o.n = s.n + 2'd1;
    return o;
  endfunction

  function automatic lex_t f_push(input lex_t s, input logic [7:0] b);
    lex_t o;
    o = s;
    if (s.st.held_valid) begin
      o = f_emit(o, s.st.held_byte, 1'b0);
    end
    o.st.held_byte  = b;
    o.st.held_valid = 1'b1;
    if (s.st.token_length < 2'd2) begin
      o.st.token_length = s.st.token_length + 2'd1;
    end
    return o;
  endfunction

  function automatic lex_t f_close(input lex_t s);
    lex_t o;
    o = s;
    if (s.st.held_valid) begin
      o = f_emit(o, s.st.held_byte, 1'b1);
    end
    o.st.held_valid       = 1'b0;
    o.st.held_byte        = '0;
    o.st.token_length     = '0;
    o.st.quoted_mode      = 1'b0;
    o.st.raw_literal_mode = 1'b0;
    o.st.previous_byte    = '0;
    return o;
  endfunction

  lex_state_t state;
  lex_t       step;
  logic [7:0] c;

  result_t        queue [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic [QAW:0]   count_next;
  logic           accept;
  logic           pop;
  logic [1:0]     push_n;

  assign c = text.in_byte;

  always_comb begin
    step    = '0;
    step.st = state;
    if (text.kind == KIND_EOI) begin
      step = f_close(step);
      step.st.comment_mode = 1'b0;
    end else if (state.comment_mode) begin
      if (c == CH_NL) begin
        step.st.comment_mode = 1'b0;
      end
    end else if (!state.quoted_mode && c == CH_HASH) begin
      step.st.comment_mode = 1'b1;
      if (state.token_length != 2'd0) begin
        step = f_close(step);
      end else begin
        step.st.previous_byte = c;
      end
    end else if (c == CH_NL) begin
      if (!state.quoted_mode) begin
        if (state.token_length != 2'd0) begin
          step = f_close(step);
        end else begin
          step.st.previous_byte = c;
        end
      end else begin
        step = f_push(step, CH_SPACE);
        step.st.previous_byte = c;
      end
    end else if (c == CH_QUOTE && !state.quoted_mode && state.token_length == 2'd0) begin
      step.st.quoted_mode = 1'b1;
      step = f_push(step, c);
      step.st.previous_byte = c;
    end else if (c == CH_QUOTE && !state.quoted_mode && state.token_length == 2'd1 &&
                 state.held_valid && state.held_byte == CH_R) begin
      step.st.raw_literal_mode = 1'b1;
      step.st.held_byte        = CH_QUOTE;
      step.st.previous_byte    = c;
    end else if (c == CH_LPAREN && state.raw_literal_mode && state.token_length == 2'd1) begin
      step.st = state;
    end else if (c == CH_QUOTE && state.raw_literal_mode &&
                 state.previous_byte == CH_RPAREN) begin
      step.st.held_byte = CH_QUOTE;
      step = f_close(step);
    end else if (c == CH_QUOTE && state.quoted_mode && state.previous_byte != CH_BSLASH) begin
      step = f_push(step, c);
      step = f_close(step);
    end else if (!state.quoted_mode && !state.raw_literal_mode && is_space(c)) begin
      if (state.token_length != 2'd0) begin
        step = f_close(step);
      end else begin
        step.st.previous_byte = c;
      end
    end else if (!state.quoted_mode && !state.raw_literal_mode &&
                 (c == CH_LBRACE || c == CH_RBRACE || c == CH_EQUALS)) begin
      if (state.token_length != 2'd0) begin
        step = f_close(step);
      end
      step = f_emit(step, c, 1'b1);
      step.st.previous_byte = '0;
    end else begin
      step = f_push(step, c);
      step.st.previous_byte = c;
    end
  end

  assign text.ready       = (count <= (QAW+1)'(QDEPTH - 2));
  assign accept           = text.valid && text.ready;
  assign tokens.valid     = (count != '0);
  assign tokens.out_byte  = queue[rd_ptr].out_byte;
  assign tokens.token_end = queue[rd_ptr].token_end;
  assign pop              = tokens.valid && tokens.ready;
  assign push_n           = accept ? step.n : 2'd0;
  assign count_next       = count + (QAW+1)'(push_n) - (QAW+1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= '0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        state <= step.st;
      end
      if (push_n != 2'd0) begin
        queue[wr_ptr] <= step.r0;
      end
      if (push_n == 2'd2) begin
        queue[wr_ptr + QAW'(1)] <= step.r1;
      end
      wr_ptr <= wr_ptr + QAW'(push_n);
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      count <= count_next;
    end
  end

endmodule

/* rtl/bsl_checker.sv */
module bsl_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       token_end
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(token_end))
    else $error("stalled result changed");

  a_full_has_data: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  a_result_has_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("result appeared without an accepted item");

endmodule

bind brace_script_lexer_core bsl_checker u_bsl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (text.valid),
  .in_ready  (text.ready),
  .out_valid (tokens.valid),
  .out_ready (tokens.ready),
  .out_byte  (tokens.out_byte),
  .token_end (tokens.token_end)
);
